### design/ugfb_pkg.sv
// ----------------------------------------------------------------------------
// ugfb_pkg
// Shared types, range table and divider constants for the four-byte encoder.
// ----------------------------------------------------------------------------
package ugfb_pkg;

   localparam int CP_W        = 21;
   localparam int RANGE_COUNT = 13;

   typedef logic [CP_W-1:0] cp_type;

   typedef struct packed {
      logic   hit;
      cp_type delta;
   } match_type;

   localparam cp_type INDEX_BASE = 21'd1687218;
   localparam logic [7:0] DIGIT_BASE = 8'h30;
   localparam logic [7:0] LEAD_BASE  = 8'h81;
   localparam int DIGIT_RADIX = 10;
   localparam int MID_RADIX   = 126;

   // reciprocal multipliers, exact over each stage's input range
   localparam logic [21:0] DIV10_WIDE_MUL = 22'd3355444;  // shift 25
   localparam logic [17:0] DIV126_MUL     = 18'd133153;   // shift 24
   localparam logic [9:0]  DIV10_NARROW_MUL = 10'd820;    // shift 13

   localparam cp_type RANGE_FIRST [RANGE_COUNT] = '{
      21'h00452, 21'h02643, 21'h0361B, 21'h03CE1, 21'h04160, 21'h044D7, 21'h0478E,
      21'h049B8, 21'h09FA6, 21'h0E865, 21'h0FA2A, 21'h0FFE6, 21'h10000
   };

   localparam cp_type RANGE_LAST [RANGE_COUNT] = '{
      21'h0200F, 21'h02E80, 21'h03917, 21'h04055, 21'h04336, 21'h0464B, 21'h04946,
      21'h04C76, 21'h0D7FF, 21'h0F92B, 21'h0FE2F, 21'h0FFFF, 21'h10FFFF
   };

   localparam cp_type RANGE_OFFSET [RANGE_COUNT] = '{
      21'd1688038, 21'd1696437, 21'd1700191, 21'd1701916, 21'd1703065,
      21'd1703947, 21'd1704636, 21'd1705179, 21'd1706261, 21'd1720768,
      21'd1725296, 21'd1726612, 21'd1876218
   };

endpackage

### design/ugfb_if.sv
// ----------------------------------------------------------------------------
// ugfb channel interfaces
// Valid/ready channels for code point requests and encoded responses.
// ----------------------------------------------------------------------------
interface ugfb_req_if;
   logic        valid;
   logic        ready;
   logic [20:0] code_point;

   modport source (output valid, output code_point, input ready);
   modport sink   (input valid, input code_point, output ready);
endinterface

interface ugfb_rsp_if;
   logic       valid;
   logic       ready;
   logic       status;
   logic [7:0] byte_first;
   logic [7:0] byte_second;
   logic [7:0] byte_third;
   logic [7:0] byte_fourth;

   modport source (output valid, output status, output byte_first, output byte_second,
                   output byte_third, output byte_fourth, input ready);
   modport sink   (input valid, input status, input byte_first, input byte_second,
                   input byte_third, input byte_fourth, output ready);
endinterface

### design/unicode_to_gb18030_four_byte_unit.sv
// ----------------------------------------------------------------------------
// unicode_to_gb18030_four_byte_unit
// Pipelined encoder from Unicode code points to GB18030 four-byte sequences.
//
// req carries one code point per beat, rsp one result per beat: status plus
// four bytes. status 1 marks a code point outside every four-byte range, and
// then all bytes are zero.
// Six register stages: range compare, index add, divide by 10, divide by 126,
// divide by 10, byte assembly. rsp valid comes from the byte assembly stage;
// throughput is one beat per cycle while rsp.ready stays high, set by the
// multiplier-based constant dividers that each own a stage.
// Reset empties every stage; req.ready is high right after reset.
// When rsp.ready is low, stages fill up behind the held output beat and
// req.ready drops only once every stage holds a beat; nothing is lost or
// repeated.
// ----------------------------------------------------------------------------
module unicode_to_gb18030_four_byte_unit
   import ugfb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   ugfb_req_if.sink    req_bus,
   ugfb_rsp_if.source  rsp_bus
);

   match_type match;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

   logic hit1_ff, hit2_ff, hit3_ff, hit4_ff, hit5_ff;
   cp_type cp1_ff, delta1_ff, idx2_ff, idx3_ff;
   logic [16:0] q1_3_ff, q1_4_ff;
   logic [9:0]  q2_4_ff, q2_5_ff;
   logic [3:0]  r1_4_ff, r1_5_ff;
   logic [6:0]  r2_5_ff, q3_5_ff;

   logic       status_ff;
   logic [7:0] b1_ff, b2_ff, b3_ff, b4_ff;

   cp_type      idx2_in;
   logic [42:0] prod3;
   logic [16:0] q1_3_in;
   cp_type      rem4;
   logic [34:0] prod4;
   logic [3:0]  r1_4_in;
   logic [9:0]  q2_4_in;
   logic [16:0] rem5;
   logic [19:0] prod5;
   logic [6:0]  r2_5_in, q3_5_in;
   logic [9:0]  rem6;
   logic [3:0]  r3;
   logic       status_in;
   logic [7:0] b1_in, b2_in, b3_in, b4_in;

   ugfb_range_match u_match (
      .code_point (req_bus.code_point),
      .match      (match)
   );

   // stall chain
   assign rdy6 = !v6_ff || rsp_bus.ready;
   assign rdy5 = !v5_ff || rdy6;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_bus.ready = rdy1;

   always_comb begin
      idx2_in = cp1_ff + delta1_ff;

      prod3   = 43'(idx2_ff) * 43'(DIV10_WIDE_MUL);
      q1_3_in = prod3[41:25];

      rem4    = idx3_ff - 21'(q1_3_ff) * 21'(DIGIT_RADIX);
      r1_4_in = rem4[3:0];
      prod4   = 35'(q1_3_ff) * 35'(DIV126_MUL);
      q2_4_in = prod4[33:24];

      rem5    = q1_4_ff - 17'(q2_4_ff) * 17'(MID_RADIX);
      r2_5_in = rem5[6:0];
      prod5   = 20'(q2_4_ff) * 20'(DIV10_NARROW_MUL);
      q3_5_in = prod5[19:13];

      rem6    = q2_5_ff - 10'(q3_5_ff) * 10'(DIGIT_RADIX);
      r3      = rem6[3:0];

      status_in = !hit5_ff;
      b1_in = '0;
      b2_in = '0;
      b3_in = '0;
      b4_in = '0;
      if (hit5_ff) begin
         b1_in = LEAD_BASE + 8'(q3_5_ff);
         b2_in = DIGIT_BASE + 8'(r3);
         b3_in = LEAD_BASE + 8'(r2_5_ff);
         b4_in = DIGIT_BASE + 8'(r1_5_ff);
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_bus.valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
         if (rdy6) v6_ff <= v5_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (rdy1) begin
         hit1_ff   <= match.hit;
         delta1_ff <= match.delta;
         cp1_ff    <= req_bus.code_point;
      end
      if (rdy2) begin
         hit2_ff <= hit1_ff;
         idx2_ff <= idx2_in;
      end
      if (rdy3) begin
         hit3_ff <= hit2_ff;
         idx3_ff <= idx2_ff;
         q1_3_ff <= q1_3_in;
      end
      if (rdy4) begin
         hit4_ff <= hit3_ff;
         r1_4_ff <= r1_4_in;
         q1_4_ff <= q1_3_ff;
         q2_4_ff <= q2_4_in;
      end
      if (rdy5) begin
         hit5_ff <= hit4_ff;
         r1_5_ff <= r1_4_ff;
         r2_5_ff <= r2_5_in;
         q2_5_ff <= q2_4_ff;
         q3_5_ff <= q3_5_in;
      end
      if (rdy6) begin
         status_ff <= status_in;
         b1_ff     <= b1_in;
         b2_ff     <= b2_in;
         b3_ff     <= b3_in;
         b4_ff     <= b4_in;
      end
   end

   assign rsp_bus.valid       = v6_ff;
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.byte_first  = b1_ff;
   assign rsp_bus.byte_second = b2_ff;
   assign rsp_bus.byte_third  = b3_ff;
   assign rsp_bus.byte_fourth = b4_ff;

endmodule

### design/ugfb_range_match.sv
// ----------------------------------------------------------------------------
// ugfb_range_match
// Compares a code point against all mapped ranges and returns the index delta.
// ----------------------------------------------------------------------------
module ugfb_range_match
   import ugfb_pkg::*;
(
   input  cp_type    code_point,
   output match_type match
);

   always_comb begin
      match = '0;
      for (int k = RANGE_COUNT - 1; k >= 0; k--) begin
         if (code_point >= RANGE_FIRST[k] && code_point <= RANGE_LAST[k]) begin
            match.hit   = 1'b1;
            match.delta = cp_type'(RANGE_OFFSET[k] - INDEX_BASE - RANGE_FIRST[k]);
         end
      end
   end

endmodule

### test/ugfb_result_checker.sv
// ----------------------------------------------------------------------------
// ugfb_result_checker
// Watches the request and response channels of the four-byte encoder. Every
// accepted code point is encoded here into its expected status and bytes, and
// every accepted response beat is compared field by field with the oldest
// expected encoding. Counts of mismatches and outstanding beats go to the top.
// ----------------------------------------------------------------------------
module ugfb_result_checker
   import ugfb_pkg::*;
(
   input  logic clock,
   input  logic reset,
   ugfb_req_if  req_mon,
   ugfb_rsp_if  rsp_mon,
   output int   mismatch_count,
   output int   open_count,
   output int   encoded_count,
   output int   unmapped_count
);

   localparam logic ENCODED    = 1'b0;
   localparam logic NO_MAPPING = 1'b1;

   localparam int          SPAN_COUNT   = 13;
   localparam int unsigned LINEAR_BASE  = 1687218;
   localparam logic [7:0]  DIGIT_OFFSET = 8'h30;
   localparam logic [7:0]  LEAD_OFFSET  = 8'h81;

   localparam int unsigned SPAN_FIRST [SPAN_COUNT] = '{
      'h00452, 'h02643, 'h0361B, 'h03CE1, 'h04160, 'h044D7, 'h0478E,
      'h049B8, 'h09FA6, 'h0E865, 'h0FA2A, 'h0FFE6, 'h10000
   };
   localparam int unsigned SPAN_LAST [SPAN_COUNT] = '{
      'h0200F, 'h02E80, 'h03917, 'h04055, 'h04336, 'h0464B, 'h04946,
      'h04C76, 'h0D7FF, 'h0F92B, 'h0FE2F, 'h0FFFF, 'h10FFFF
   };
   localparam int unsigned SPAN_BASE [SPAN_COUNT] = '{
      1688038, 1696437, 1700191, 1701916, 1703065, 1703947, 1704636,
      1705179, 1706261, 1720768, 1725296, 1726612, 1876218
   };

   typedef struct packed {
      logic       status;
      logic [7:0] byte_first;
      logic [7:0] byte_second;
      logic [7:0] byte_third;
      logic [7:0] byte_fourth;
   } gb_bytes_type;

   gb_bytes_type pending_encodings [$];

   function automatic gb_bytes_type encode_gb18030(input cp_type cp);
      gb_bytes_type enc;
      int unsigned  linear;
      int           span;
      enc = '0;
      enc.status = NO_MAPPING;
      span = -1;
      for (int k = 0; k < SPAN_COUNT; k++) begin
         if (span < 0 && cp >= SPAN_FIRST[k] && cp <= SPAN_LAST[k]) span = k;
      end
      if (span >= 0) begin
         linear = SPAN_BASE[span] + (cp - SPAN_FIRST[span]) - LINEAR_BASE;
         enc.status      = ENCODED;
         enc.byte_fourth = DIGIT_OFFSET + 8'(linear % 10);
         linear          = linear / 10;
         enc.byte_third  = LEAD_OFFSET + 8'(linear % 126);
         linear          = linear / 126;
         enc.byte_second = DIGIT_OFFSET + 8'(linear % 10);
         linear          = linear / 10;
         enc.byte_first  = LEAD_OFFSET + 8'(linear);
      end
      return enc;
   endfunction

   task automatic compare_field(input string field, input logic [7:0] want,
                                input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %02h, got %02h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      gb_bytes_type seen;
      gb_bytes_type want;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready)
            pending_encodings.push_back(encode_gb18030(req_mon.code_point));
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen = {rsp_mon.status, rsp_mon.byte_first, rsp_mon.byte_second,
                    rsp_mon.byte_third, rsp_mon.byte_fourth};
            if (pending_encodings.size() == 0) begin
               $display("%0t: response beat with none expected, got %h", $time, seen);
               mismatch_count++;
            end else begin
               want = pending_encodings.pop_front();
               compare_field("status", 8'(want.status), 8'(seen.status));
               compare_field("byte_first", want.byte_first, seen.byte_first);
               compare_field("byte_second", want.byte_second, seen.byte_second);
               compare_field("byte_third", want.byte_third, seen.byte_third);
               compare_field("byte_fourth", want.byte_fourth, seen.byte_fourth);
               if (want.status == ENCODED) encoded_count++;
               else unmapped_count++;
            end
         end
      end
      open_count <= pending_encodings.size();
   end

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Regression for unicode_to_gb18030_four_byte_unit. Sends range edges, gaps,
// surrogates and out-of-range code points first, then random code points
// drawn inside ranges, around range edges, in the BMP and over all 21 bits.
// Both channels idle at random, and the response side holds off once for a
// long stretch so the pipeline fills and stalls its input.
// ----------------------------------------------------------------------------
module tb;
   import ugfb_pkg::*;

   localparam int RANDOM_ITEMS = 1500;
   localparam int IDLE_LIMIT   = 1000;
   localparam int DRAIN_CYCLES = 12;
   localparam int LONG_HOLD    = 80;
   localparam int HOLD_AT_BEAT = 400;
   localparam int MAX_GAP      = 11;

   localparam cp_type EDGE_POINTS [25] = '{
      21'h000000, 21'h000451, 21'h000452, 21'h00200F, 21'h002010,
      21'h002643, 21'h002E80, 21'h004C76, 21'h004C77, 21'h009FA5,
      21'h009FA6, 21'h00D7FF, 21'h00D800, 21'h00DFFF, 21'h00E865,
      21'h00F92B, 21'h00FA2A, 21'h00FE2F, 21'h00FFE5, 21'h00FFE6,
      21'h00FFFF, 21'h010000, 21'h10FFFF, 21'h110000, 21'h1FFFFF
   };

   logic clock = 1'b0;
   logic reset;

   ugfb_req_if req_bus ();
   ugfb_rsp_if rsp_bus ();

   int  mismatch_count;
   int  open_count;
   int  encoded_count;
   int  unmapped_count;
   int  sent_count = 0;
   bit  sender_burst = 1'b0;

   always #5 clock = ~clock;

   unicode_to_gb18030_four_byte_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   ugfb_result_checker result_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .mismatch_count (mismatch_count),
      .open_count     (open_count),
      .encoded_count  (encoded_count),
      .unmapped_count (unmapped_count)
   );

   task automatic send_code_point(input cp_type cp);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.code_point <= cp;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      sent_count++;
      if (sent_count % 64 == 0) sender_burst = ($urandom_range(0, 3) == 0);
   endtask

   function automatic cp_type pick_code_point();
      int     span;
      cp_type cp;
      span = $urandom_range(0, RANGE_COUNT - 1);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: cp = RANGE_FIRST[span]
                          + cp_type'($urandom_range(0, RANGE_LAST[span] - RANGE_FIRST[span]));
         4, 5: begin
            case ($urandom_range(0, 3))
               0: cp = RANGE_FIRST[span] - 1'b1;
               1: cp = RANGE_FIRST[span];
               2: cp = RANGE_LAST[span];
               default: cp = RANGE_LAST[span] + 1'b1;
            endcase
         end
         6, 7, 8: cp = cp_type'($urandom());
         default: cp = cp_type'($urandom_range(0, 16'hFFFF));
      endcase
      return cp;
   endfunction

   // stimulus and verdict
   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.code_point = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      foreach (EDGE_POINTS[i]) send_code_point(EDGE_POINTS[i]);
      repeat (RANDOM_ITEMS) send_code_point(pick_code_point());
      req_bus.valid <= 1'b0;
      while (open_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d code points (edges, gaps, surrogates, full 21-bit range)",
               sent_count);
      $display("checked %0d encoded and %0d unmapped beats under random stalls",
               encoded_count, unmapped_count);
      if (mismatch_count == 0) begin
         $display("unicode_to_gb18030_four_byte_unit regression: pass");
      end else begin
         $display("unicode_to_gb18030_four_byte_unit regression: fail");
      end
      $finish;
   end

   // response side backpressure, with one long hold-off
   initial begin
      int stall;
      int taken;
      bit burst;
      bit held;
      rsp_bus.ready = 1'b0;
      taken = 0;
      burst = 1'b0;
      held  = 1'b0;
      @(negedge clock);
      forever begin
         stall = burst ? 0 : $urandom_range(0, MAX_GAP);
         if (!held && taken >= HOLD_AT_BEAT) begin
            held  = 1'b1;
            stall = LONG_HOLD;
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_bus.valid && rsp_bus.ready)) @(posedge clock);
         @(negedge clock);
         taken++;
         if (taken % 50 == 0) burst = ($urandom_range(0, 3) == 0);
      end
   end

   // watchdog on cycles without any beat
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no beat for %0d cycles, %0d responses outstanding",
               $time, IDLE_LIMIT, open_count);
      $display("unicode_to_gb18030_four_byte_unit regression: fail");
      $finish;
   end

endmodule
